[rtl/core/mbp_pkg.sv]
`default_nettype none

package mbp_pkg;

    // sizes of the pyramid and of one sample
    localparam int MAX_DIM_LOG2 = 11;
    localparam int CHANNELS     = 4;
    localparam int SAMPLE_W     = 16;

    // derived widths
    localparam int LVL_W    = $clog2(MAX_DIM_LOG2 + 1);
    localparam int POS_W    = MAX_DIM_LOG2;
    localparam int DIM_W    = MAX_DIM_LOG2 + 1;
    localparam int XY_W     = MAX_DIM_LOG2 - 1;
    localparam int SUM_W    = SAMPLE_W + 2;
    localparam int ROW_DEPTH = 1 << MAX_DIM_LOG2;
    localparam int ROW_AW   = MAX_DIM_LOG2;
    localparam int ROW_W    = CHANNELS * SUM_W;

    // configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [CNT_W-1:0] CHAN_RESET = 3'd4;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] t_samples;
    typedef logic [CHANNELS-1:0][SUM_W-1:0]    t_lanes;

    // input beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] chan_a;
        logic [SAMPLE_W-1:0] chan_b;
        logic [SAMPLE_W-1:0] chan_c;
        logic [SAMPLE_W-1:0] chan_d;
    } t_pix_in;

    // result beat
    typedef struct packed {
        logic [LVL_W-1:0]    level;
        logic [XY_W-1:0]     texel_x;
        logic [XY_W-1:0]     texel_y;
        logic [SAMPLE_W-1:0] out_a;
        logic [SAMPLE_W-1:0] out_b;
        logic [SAMPLE_W-1:0] out_c;
        logic [SAMPLE_W-1:0] out_d;
        logic                run_end;
    } t_pix_out;

    // saturated image geometry
    typedef struct packed {
        logic [LVL_W-1:0] wl;
        logic [LVL_W-1:0] hl;
        logic [LVL_W-1:0] nlev;
    } t_geom;

    // row store access
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ROW_AW-1:0] addr;
        t_lanes            wdata;
    } t_row_req;

    // shared adder operation
    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_DOUBLE = 1'b1
    } t_sum_op;

endpackage

`default_nettype wire

[rtl/core/mbp_ram.sv]
`default_nettype none

module mbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/mbp_sum_unit.sv]
`default_nettype none

module mbp_sum_unit (
    input  wire mbp_pkg::t_sum_op i_op,
    input  wire mbp_pkg::t_lanes  i_a,
    input  wire mbp_pkg::t_lanes  i_b,
    output mbp_pkg::t_lanes       o_sum
);

    // one adder per channel, shared by the horizontal and vertical steps
    always_comb begin
        for (int c = 0; c < mbp_pkg::CHANNELS; c++) begin
            if (i_op == mbp_pkg::OP_DOUBLE) begin
                o_sum[c] = {i_a[c][mbp_pkg::SUM_W-2:0], 1'b0};
            end else begin
                o_sum[c] = i_a[c] + i_b[c];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/mbp_ctrl.sv]
`default_nettype none

module mbp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire mbp_pkg::t_samples i_samples,
    input  wire mbp_pkg::t_geom    i_geom,
    input  wire logic              i_clr,
    output logic                   o_ready,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output mbp_pkg::t_pix_out      o_res,
    output mbp_pkg::t_row_req      o_row_req,
    input  wire mbp_pkg::t_lanes   i_row_rdata,
    output mbp_pkg::t_sum_op       o_sum_op,
    output mbp_pkg::t_lanes        o_sum_a,
    output mbp_pkg::t_lanes        o_sum_b,
    input  wire mbp_pkg::t_lanes   i_sum
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HORZ = 4'b0010,
        S_VERT = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [mbp_pkg::LVL_W-1:0]  r_lvl;
    logic [mbp_pkg::ROW_AW-1:0] r_base;
    logic [mbp_pkg::POS_W-1:0]  r_col [mbp_pkg::MAX_DIM_LOG2];
    logic [mbp_pkg::POS_W-1:0]  r_row [mbp_pkg::MAX_DIM_LOG2];
    mbp_pkg::t_samples          r_hold [mbp_pkg::MAX_DIM_LOG2];
    mbp_pkg::t_samples          r_v;
    mbp_pkg::t_lanes            r_hs;
    logic [mbp_pkg::XY_W-1:0]   r_px;
    logic [mbp_pkg::XY_W-1:0]   r_py;
    logic [mbp_pkg::ROW_AW-1:0] r_addr;
    logic                       r_h_one;
    logic                       r_row_odd;
    logic                       r_pend_vld;
    mbp_pkg::t_pix_out          r_pend;
    logic                       r_res_vld;
    mbp_pkg::t_pix_out          r_res;

    logic [mbp_pkg::POS_W-1:0]  col, row;
    logic                       w_one, h_one;
    logic [mbp_pkg::DIM_W-1:0]  w_size, h_size;
    logic                       col_wrap, row_wrap;
    logic                       hold_case;
    logic [mbp_pkg::XY_W-1:0]   px, py;
    logic [mbp_pkg::ROW_AW-1:0] row_addr, base_step;
    logic                       out_free, emit, stall, load, load_last;
    logic [mbp_pkg::LVL_W-1:0]  lvl_next;
    mbp_pkg::t_samples          v_new;
    mbp_pkg::t_pix_out          res_next;

    // position and size of the current level
    always_comb begin
        col      = r_col[r_lvl];
        row      = r_row[r_lvl];
        w_one    = (i_geom.wl <= r_lvl);
        h_one    = (i_geom.hl <= r_lvl);
        w_size   = w_one ? mbp_pkg::DIM_W'(1)
                         : (mbp_pkg::DIM_W'(1) << (i_geom.wl - r_lvl));
        h_size   = h_one ? mbp_pkg::DIM_W'(1)
                         : (mbp_pkg::DIM_W'(1) << (i_geom.hl - r_lvl));
        col_wrap = (mbp_pkg::DIM_W'(col) + mbp_pkg::DIM_W'(1)) >= w_size;
        row_wrap = (mbp_pkg::DIM_W'(row) + mbp_pkg::DIM_W'(1)) >= h_size;
        hold_case = !w_one && !col[0];
        px       = w_one ? '0 : col[mbp_pkg::POS_W-1:1];
        py       = h_one ? '0 : row[mbp_pkg::POS_W-1:1];
        row_addr = r_base + mbp_pkg::ROW_AW'(px);
        base_step = w_one ? mbp_pkg::ROW_AW'(1) : mbp_pkg::ROW_AW'(w_size >> 1);
        lvl_next = r_lvl + mbp_pkg::LVL_W'(1);
    end

    // truncated quarter of the four-texel sum
    always_comb begin
        for (int c = 0; c < mbp_pkg::CHANNELS; c++) begin
            v_new[c] = i_sum[c][mbp_pkg::SUM_W-1:2];
        end
    end

    // result staging: pending slot feeds the output register
    always_comb begin
        out_free  = !r_res_vld || i_res_ready;
        emit      = r_h_one || r_row_odd;
        stall     = emit && r_pend_vld && !out_free;
        load      = 1'b0;
        load_last = 1'b0;
        if (r_state == S_VERT && emit && !stall) begin
            load = r_pend_vld;
        end
        if (r_state == S_FIN && r_pend_vld && out_free) begin
            load      = 1'b1;
            load_last = 1'b1;
        end
        res_next         = r_pend;
        res_next.run_end = load_last;
    end

    // shared adder operands and row store access
    always_comb begin
        o_sum_op = mbp_pkg::OP_ADD;
        for (int c = 0; c < mbp_pkg::CHANNELS; c++) begin
            o_sum_a[c] = mbp_pkg::SUM_W'(r_v[c]);
            o_sum_b[c] = mbp_pkg::SUM_W'(r_hold[r_lvl][c]);
        end
        o_row_req.en    = 1'b0;
        o_row_req.we    = 1'b0;
        o_row_req.addr  = row_addr;
        o_row_req.wdata = r_hs;
        case (r_state)
            S_HORZ: begin
                o_sum_op     = w_one ? mbp_pkg::OP_DOUBLE : mbp_pkg::OP_ADD;
                o_row_req.en = 1'b1;
            end
            S_VERT: begin
                o_sum_op       = r_h_one ? mbp_pkg::OP_DOUBLE : mbp_pkg::OP_ADD;
                o_sum_a        = r_hs;
                o_sum_b        = i_row_rdata;
                o_row_req.addr = r_addr;
                o_row_req.en   = !emit;
                o_row_req.we   = !emit;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_geom.nlev == '0) ? S_IDLE : S_HORZ;
                end
            end
            S_HORZ: begin
                if (hold_case) begin
                    n_state = r_pend_vld ? S_FIN : S_IDLE;
                end else begin
                    n_state = S_VERT;
                end
            end
            S_VERT: begin
                if (!emit) begin
                    n_state = r_pend_vld ? S_FIN : S_IDLE;
                end else if (!stall) begin
                    n_state = (lvl_next == i_geom.nlev) ? S_FIN : S_HORZ;
                end
            end
            S_FIN: begin
                if (!r_pend_vld || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lvl      <= '0;
            r_pend_vld <= 1'b0;
            r_res_vld  <= 1'b0;
            for (int l = 0; l < mbp_pkg::MAX_DIM_LOG2; l++) begin
                r_col[l] <= '0;
                r_row[l] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (load) begin
                r_res_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_res_vld <= 1'b0;
            end
            if (r_state == S_IDLE && i_start) begin
                r_lvl <= '0;
            end
            if (r_state == S_VERT && emit && !stall) begin
                r_lvl      <= lvl_next;
                r_pend_vld <= 1'b1;
            end
            if (load_last) begin
                r_pend_vld <= 1'b0;
            end
            // level position counters
            if (i_clr) begin
                for (int l = 0; l < mbp_pkg::MAX_DIM_LOG2; l++) begin
                    r_col[l] <= '0;
                    r_row[l] <= '0;
                end
            end else if (r_state == S_HORZ) begin
                if (col_wrap) begin
                    r_col[r_lvl] <= '0;
                    r_row[r_lvl] <= row_wrap ? '0 : row + mbp_pkg::POS_W'(1);
                end else begin
                    r_col[r_lvl] <= col + mbp_pkg::POS_W'(1);
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_v    <= i_samples;
            r_base <= '0;
        end
        if (r_state == S_HORZ) begin
            if (hold_case) begin
                r_hold[r_lvl] <= r_v;
            end else begin
                r_hs      <= i_sum;
                r_px      <= px;
                r_py      <= py;
                r_addr    <= row_addr;
                r_h_one   <= h_one;
                r_row_odd <= row[0];
                r_base    <= r_base + base_step;
            end
        end
        if (r_state == S_VERT && emit && !stall) begin
            r_v            <= v_new;
            r_pend.level   <= lvl_next;
            r_pend.texel_x <= r_px;
            r_pend.texel_y <= r_py;
            r_pend.out_a   <= v_new[0];
            r_pend.out_b   <= v_new[1];
            r_pend.out_c   <= v_new[2];
            r_pend.out_d   <= v_new[3];
            r_pend.run_end <= 1'b0;
        end
        if (load) begin
            r_res <= res_next;
        end
    end

    // no pixel beat is taken while reset is held
    assign o_ready     = (r_state == S_IDLE) && i_rst_n;
    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

endmodule

`default_nettype wire

[rtl/core/mipmap_box_pyramid.sv]
`default_nettype none

// channel   direction  handshake                    beat
// pix       in         i_pix_valid / o_pix_ready    t_pix_in: four 16-bit samples
// res       out        o_res_valid / i_res_ready    t_pix_out: level, x, y, four averages
// cfg       in         i_cfg_we (no wait)           index i_cfg_idx, data i_cfg_data
//
// a pixel is taken in the idle state; each coarser texel it completes takes a horizontal
// then a vertical pass through the shared per-channel adder; it then parks in a pair
// register or ends in the single-port row store, and a final state hands over its last
// result when it has any; a one-pixel image is taken at one pixel per cycle.
// reset (synchronous, active low) clears the level counters; stores are never cleared.
// a stalled result beat holds the sequencer once a second result is ready.

module mipmap_box_pyramid (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mbp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [mbp_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                            i_pix_valid,
    output logic                                 o_pix_ready,
    input  wire mbp_pkg::t_pix_in                i_pix,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_ready,
    output mbp_pkg::t_pix_out                    o_res
);

    logic [mbp_pkg::CFG_W-1:0] r_width_log2;
    logic [mbp_pkg::CFG_W-1:0] r_height_log2;
    logic [mbp_pkg::CNT_W-1:0] r_chan_count;

    logic                      cfg_hit;
    logic [mbp_pkg::CNT_W-1:0] nch;
    logic [mbp_pkg::LVL_W-1:0] wl, hl;
    mbp_pkg::t_geom            geom;
    mbp_pkg::t_samples         chans, samples;
    mbp_pkg::t_row_req         row_req;
    mbp_pkg::t_lanes           row_rdata;
    mbp_pkg::t_sum_op          sum_op;
    mbp_pkg::t_lanes           sum_a, sum_b, sum_y;
    logic                      start;

    // configuration registers
    always_comb begin
        cfg_hit = 1'b0;
        case (i_cfg_idx)
            mbp_pkg::CFG_WIDTH_LOG2,
            mbp_pkg::CFG_HEIGHT_LOG2,
            mbp_pkg::CFG_CHANNEL_COUNT: cfg_hit = i_cfg_we;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_log2  <= '0;
            r_height_log2 <= '0;
            r_chan_count  <= mbp_pkg::CHAN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mbp_pkg::CFG_WIDTH_LOG2:    r_width_log2  <= i_cfg_data;
                mbp_pkg::CFG_HEIGHT_LOG2:   r_height_log2 <= i_cfg_data;
                mbp_pkg::CFG_CHANNEL_COUNT: r_chan_count  <= i_cfg_data[mbp_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // saturated geometry and channel count
    always_comb begin
        wl = (r_width_log2 > mbp_pkg::CFG_W'(mbp_pkg::MAX_DIM_LOG2))
             ? mbp_pkg::LVL_W'(mbp_pkg::MAX_DIM_LOG2) : mbp_pkg::LVL_W'(r_width_log2);
        hl = (r_height_log2 > mbp_pkg::CFG_W'(mbp_pkg::MAX_DIM_LOG2))
             ? mbp_pkg::LVL_W'(mbp_pkg::MAX_DIM_LOG2) : mbp_pkg::LVL_W'(r_height_log2);
        geom.wl   = wl;
        geom.hl   = hl;
        geom.nlev = (wl > hl) ? wl : hl;
        if (r_chan_count == '0) begin
            nch = mbp_pkg::CNT_W'(1);
        end else if (r_chan_count > mbp_pkg::CNT_W'(mbp_pkg::CHANNELS)) begin
            nch = mbp_pkg::CNT_W'(mbp_pkg::CHANNELS);
        end else begin
            nch = r_chan_count;
        end
    end

    // unused channels enter as zero and so average to zero
    always_comb begin
        chans[0] = i_pix.chan_a;
        chans[1] = i_pix.chan_b;
        chans[2] = i_pix.chan_c;
        chans[3] = i_pix.chan_d;
        for (int c = 0; c < mbp_pkg::CHANNELS; c++) begin
            samples[c] = (mbp_pkg::CNT_W'(c) < nch) ? chans[c] : '0;
        end
    end

    assign start = i_pix_valid && o_pix_ready;

    mbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_samples   (samples),
        .i_geom      (geom),
        .i_clr       (cfg_hit),
        .o_ready     (o_pix_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res),
        .o_row_req   (row_req),
        .i_row_rdata (row_rdata),
        .o_sum_op    (sum_op),
        .o_sum_a     (sum_a),
        .o_sum_b     (sum_b),
        .i_sum       (sum_y)
    );

    mbp_sum_unit u_sum (
        .i_op  (sum_op),
        .i_a   (sum_a),
        .i_b   (sum_b),
        .o_sum (sum_y)
    );

    // pending even-row pair sums of every level
    mbp_ram #(
        .WIDTH (mbp_pkg::ROW_W),
        .DEPTH (mbp_pkg::ROW_DEPTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_en    (row_req.en),
        .i_we    (row_req.we),
        .i_addr  (row_req.addr),
        .i_wdata (row_req.wdata),
        .o_rdata (row_rdata)
    );

endmodule

`default_nettype wire

[sim/mipmap_box_pyramid_tb.sv]
`timescale 1ns / 100ps

module mipmap_box_pyramid_tb;

    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 210;
    localparam int TAIL_LOG2     = 6;
    localparam int TAIL_PIX      = 1 << TAIL_LOG2;

    // index with no register behind it
    localparam logic [mbp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_ONE
    } t_chk;

    typedef struct packed {
        t_chk                          chk;
        logic                          is_cfg;
        logic [mbp_pkg::CFG_IDX_W-1:0] idx;
        logic [mbp_pkg::CFG_W-1:0]     value;
        mbp_pkg::t_pix_in              pix;
        mbp_pkg::t_pix_out             want;
    } t_plan_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [mbp_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [mbp_pkg::CFG_W-1:0]     i_cfg_data;
    logic                          i_pix_valid;
    logic                          o_pix_ready;
    mbp_pkg::t_pix_in              i_pix;
    logic                          o_res_valid;
    logic                          i_res_ready;
    mbp_pkg::t_pix_out             o_res;

    // predictor copy of the registers and level state
    logic [mbp_pkg::CFG_W-1:0] cfg_wl;
    logic [mbp_pkg::CFG_W-1:0] cfg_hl;
    logic [mbp_pkg::CNT_W-1:0] cfg_chans;
    int unsigned      row_sums [mbp_pkg::ROW_DEPTH][mbp_pkg::CHANNELS];
    int unsigned      held_texel [mbp_pkg::MAX_DIM_LOG2][mbp_pkg::CHANNELS];
    int unsigned      lvl_col [mbp_pkg::MAX_DIM_LOG2+1];
    int unsigned      lvl_row [mbp_pkg::MAX_DIM_LOG2+1];

    mbp_pkg::t_pix_out pending_texels [$];
    t_plan_row         plan [$];
    int        errors = 0;
    int        cycles = 0;
    bit        gaps_on = 1'b1;
    bit        quiet_tail = 1'b0;

    mipmap_box_pyramid u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_pix       (i_pix),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[mipmap_box_pyramid] ERROR");
            $finish;
        end
    end

    // append one expected texel
    task automatic add_texel(input mbp_pkg::t_pix_out t);
        pending_texels = {pending_texels, t};
    endtask

    // cascade of coarser texels completed by one base pixel, lowest level first
    task automatic predict_texels(input mbp_pkg::t_pix_in pix);
        int unsigned wl, hl, nlev, nch, lw, lh, col, row, tx, ty, idx, base;
        int unsigned v [mbp_pkg::CHANNELS];
        int unsigned hs [mbp_pkg::CHANNELS];
        int          c, lv;
        mbp_pkg::t_pix_out beat, prev;
        bit          have_prev;
        wl = (cfg_wl > mbp_pkg::MAX_DIM_LOG2) ? mbp_pkg::MAX_DIM_LOG2 : 32'(cfg_wl);
        hl = (cfg_hl > mbp_pkg::MAX_DIM_LOG2) ? mbp_pkg::MAX_DIM_LOG2 : 32'(cfg_hl);
        nlev = (wl > hl) ? wl : hl;
        nch = 32'(cfg_chans);
        if (nch < 1) nch = 1;
        if (nch > mbp_pkg::CHANNELS) nch = mbp_pkg::CHANNELS;
        v[0] = 32'(pix.chan_a);
        v[1] = 32'(pix.chan_b);
        v[2] = 32'(pix.chan_c);
        v[3] = 32'(pix.chan_d);
        for (c = 0; c < mbp_pkg::CHANNELS; c++) begin
            if (c >= nch) v[c] = 0;
        end
        base = 0;
        have_prev = 1'b0;
        prev = '0;
        for (lv = 0; lv < nlev; lv++) begin
            lw = (wl > lv) ? (1 << (wl - lv)) : 1;
            lh = (hl > lv) ? (1 << (hl - lv)) : 1;
            col = lvl_col[lv];
            row = lvl_row[lv];
            // step this level's raster position
            if (col + 1 >= lw) begin
                lvl_col[lv] = 0;
                lvl_row[lv] = (row + 1 >= lh) ? 0 : row + 1;
            end else begin
                lvl_col[lv] = col + 1;
            end
            // horizontal pair, texel repeated once the level is one wide
            if (lw == 1) begin
                for (c = 0; c < mbp_pkg::CHANNELS; c++) hs[c] = v[c] << 1;
            end else if ((col & 1) == 0) begin
                for (c = 0; c < mbp_pkg::CHANNELS; c++) held_texel[lv][c] = v[c];
                break;
            end else begin
                for (c = 0; c < mbp_pkg::CHANNELS; c++) hs[c] = held_texel[lv][c] + v[c];
            end
            tx = (lw == 1) ? 0 : (col >> 1);
            ty = (lh == 1) ? 0 : (row >> 1);
            idx = (base + tx) & (mbp_pkg::ROW_DEPTH - 1);
            // vertical pair through the row store
            if (lh == 1) begin
                for (c = 0; c < mbp_pkg::CHANNELS; c++) hs[c] = hs[c] << 1;
            end else if ((row & 1) == 0) begin
                for (c = 0; c < mbp_pkg::CHANNELS; c++) row_sums[idx][c] = hs[c];
                break;
            end else begin
                for (c = 0; c < mbp_pkg::CHANNELS; c++) hs[c] = hs[c] + row_sums[idx][c];
            end
            for (c = 0; c < mbp_pkg::CHANNELS; c++) v[c] = (c < nch) ? (hs[c] >> 2) : 0;
            if (have_prev) add_texel(prev);
            beat.level   = mbp_pkg::LVL_W'(lv + 1);
            beat.texel_x = mbp_pkg::XY_W'(tx);
            beat.texel_y = mbp_pkg::XY_W'(ty);
            beat.out_a   = mbp_pkg::SAMPLE_W'(v[0]);
            beat.out_b   = mbp_pkg::SAMPLE_W'(v[1]);
            beat.out_c   = mbp_pkg::SAMPLE_W'(v[2]);
            beat.out_d   = mbp_pkg::SAMPLE_W'(v[3]);
            beat.run_end = 1'b0;
            prev = beat;
            have_prev = 1'b1;
            base = base + ((lw == 1) ? 1 : (lw >> 1));
        end
        // last texel of the cascade carries the end marker
        if (have_prev) begin
            prev.run_end = 1'b1;
            add_texel(prev);
        end
    endtask

    // field by field compare of one result beat
    task automatic check_texel(input mbp_pkg::t_pix_out got, input mbp_pkg::t_pix_out want);
        if (got.level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, got.level);
            errors++;
        end
        if (got.texel_x !== want.texel_x) begin
            $error("texel_x: expected %0d, got %0d", want.texel_x, got.texel_x);
            errors++;
        end
        if (got.texel_y !== want.texel_y) begin
            $error("texel_y: expected %0d, got %0d", want.texel_y, got.texel_y);
            errors++;
        end
        if (got.out_a !== want.out_a) begin
            $error("out_a: expected %h, got %h", want.out_a, got.out_a);
            errors++;
        end
        if (got.out_b !== want.out_b) begin
            $error("out_b: expected %h, got %h", want.out_b, got.out_b);
            errors++;
        end
        if (got.out_c !== want.out_c) begin
            $error("out_c: expected %h, got %h", want.out_c, got.out_c);
            errors++;
        end
        if (got.out_d !== want.out_d) begin
            $error("out_d: expected %h, got %h", want.out_d, got.out_d);
            errors++;
        end
        if (got.run_end !== want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
            errors++;
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_res_valid === 1'b1 && i_res_ready === 1'b1) begin
            if (pending_texels.size() == 0) begin
                $error("result beat with nothing expected: level %0d x %0d y %0d",
                       o_res.level, o_res.texel_x, o_res.texel_y);
                errors++;
            end else begin
                check_texel(o_res, pending_texels.pop_front());
            end
        end
    end

    // result side back-pressure in bursts
    initial begin : res_stall
        int on_len, off_len;
        i_res_ready = 1'b0;
        forever begin
            on_len = $urandom_range(1, 30);
            repeat (on_len) begin
                @(negedge i_clk);
                i_res_ready <= 1'b1;
            end
            if (!quiet_tail && $urandom_range(0, 3) != 0) begin
                off_len = $urandom_range(1, 7);
                repeat (off_len) begin
                    @(negedge i_clk);
                    i_res_ready <= 1'b0;
                end
            end
        end
    end

    // let every expected texel out, then give the pipeline time to go quiet
    task automatic settle();
        @(negedge i_clk);
        i_pix_valid <= 1'b0;
        while (pending_texels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mbp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbp_pkg::CFG_W-1:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        // any known register restarts the image
        case (idx)
            mbp_pkg::CFG_WIDTH_LOG2:    cfg_wl = value;
            mbp_pkg::CFG_HEIGHT_LOG2:   cfg_hl = value;
            mbp_pkg::CFG_CHANNEL_COUNT: cfg_chans = value[mbp_pkg::CNT_W-1:0];
            default: ;
        endcase
        if (idx != CFG_UNUSED) begin
            foreach (lvl_col[i]) begin
                lvl_col[i] = 0;
                lvl_row[i] = 0;
            end
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input mbp_pkg::t_pix_in pix, input t_chk chk,
                              input mbp_pkg::t_pix_out want);
        int gap, depth;
        if (!quiet_tail && gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            @(negedge i_clk);
            i_pix_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_pix_valid <= 1'b1;
        i_pix       <= pix;
        do @(posedge i_clk); while (o_pix_ready !== 1'b1);
        // pixel beat taken, predictor runs; typed rows replace its output
        depth = pending_texels.size();
        predict_texels(pix);
        if (chk != CHK_PREDICT) begin
            while (pending_texels.size() > depth) void'(pending_texels.pop_back());
            if (chk == CHK_ONE) add_texel(want);
        end
    endtask

    function automatic mbp_pkg::t_pix_in random_pixel();
        mbp_pkg::t_pix_in pix;
        logic [mbp_pkg::SAMPLE_W-1:0] s [mbp_pkg::CHANNELS];
        int r;
        for (int c = 0; c < mbp_pkg::CHANNELS; c++) begin
            r = $urandom_range(0, 9);
            s[c] = (r == 0) ? '0 : (r == 1) ? '1
                 : mbp_pkg::SAMPLE_W'($urandom_range(0, 65535));
        end
        pix = {s[0], s[1], s[2], s[3]};
        return pix;
    endfunction

    function automatic int unsigned pick_log2();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(0, 3);
        if (r < 9) return $urandom_range(4, 6);
        return $urandom_range(7, 15);
    endfunction

    task automatic plan_cfg(input logic [mbp_pkg::CFG_IDX_W-1:0] idx,
                            input logic [mbp_pkg::CFG_W-1:0] value);
        t_plan_row row;
        row = '0;
        row.chk    = CHK_PREDICT;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.value  = value;
        plan = {plan, row};
    endtask

    task automatic plan_pix(input mbp_pkg::t_pix_in pix, input t_chk chk,
                            input mbp_pkg::t_pix_out want);
        t_plan_row row;
        row = '0;
        row.chk  = chk;
        row.pix  = pix;
        row.want = want;
        plan = {plan, row};
    endtask

    initial begin : main_seq
        mbp_pkg::t_pix_in  ones, zeros;
        mbp_pkg::t_pix_out ones_res, zero_res, none;
        int unsigned wl, hl, ch, npix, n, rand_items;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_pix_valid = 1'b0;
        i_pix       = '0;
        cfg_wl      = '0;
        cfg_hl      = '0;
        cfg_chans   = mbp_pkg::CHAN_RESET;
        foreach (lvl_col[i]) begin
            lvl_col[i] = 0;
            lvl_row[i] = 0;
        end

        ones     = {4{16'hFFFF}};
        zeros    = '0;
        ones_res = {4'd1, 10'd0, 10'd0, {4{16'hFFFF}}, 1'b1};
        zero_res = {4'd1, 10'd0, 10'd0, 64'd0, 1'b1};
        none     = '0;

        // directed rows: one-pixel image after reset gives nothing
        plan_pix(ones, CHK_NONE, none);
        plan_pix(zeros, CHK_NONE, none);
        // 2x1 image, wraps from one image to the next
        plan_cfg(mbp_pkg::CFG_WIDTH_LOG2, 4'd1);
        plan_pix(ones, CHK_NONE, none);
        plan_pix(ones, CHK_ONE, ones_res);
        plan_pix(zeros, CHK_NONE, none);
        plan_pix(zeros, CHK_ONE, zero_res);
        plan_pix({16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0}, CHK_PREDICT, none);
        plan_pix({16'h5555, 16'hAAAA, 16'hF0F0, 16'h0F0F}, CHK_PREDICT, none);
        // channel count of zero behaves as one
        plan_cfg(mbp_pkg::CFG_CHANNEL_COUNT, 4'd0);
        plan_pix({16'hAAAA, 16'h5555, 16'hFFFF, 16'h1234}, CHK_PREDICT, none);
        plan_pix({16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF}, CHK_PREDICT, none);
        // channel count above four, and a write to the spare index mid pair
        plan_cfg(mbp_pkg::CFG_CHANNEL_COUNT, 4'd7);
        plan_pix({16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE}, CHK_PREDICT, none);
        plan_cfg(CFG_UNUSED, 4'hF);
        plan_pix({16'h0001, 16'h8000, 16'hFFFE, 16'h7FFF}, CHK_PREDICT, none);
        // 1x2 image, vertical pair only
        plan_cfg(mbp_pkg::CFG_CHANNEL_COUNT, 4'd3);
        plan_cfg(mbp_pkg::CFG_WIDTH_LOG2, 4'd0);
        plan_cfg(mbp_pkg::CFG_HEIGHT_LOG2, 4'd1);
        plan_pix({16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0}, CHK_PREDICT, none);
        plan_pix({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, CHK_PREDICT, none);
        // 4x1 image, last pixel cascades into two levels
        plan_cfg(mbp_pkg::CFG_CHANNEL_COUNT, 4'd2);
        plan_cfg(mbp_pkg::CFG_WIDTH_LOG2, 4'd2);
        plan_cfg(mbp_pkg::CFG_HEIGHT_LOG2, 4'd0);
        plan_pix({16'h0102, 16'hFEDC, 16'h3333, 16'hCCCC}, CHK_PREDICT, none);
        plan_pix({16'hFFFF, 16'h0001, 16'h4444, 16'hBBBB}, CHK_PREDICT, none);
        plan_pix({16'h0000, 16'h7FFF, 16'h5A5A, 16'hA5A5}, CHK_PREDICT, none);
        plan_pix({16'hC3C3, 16'h3C3C, 16'hFFFF, 16'h0000}, CHK_PREDICT, none);
        // oversized exponents saturate; first row pixels give nothing
        plan_cfg(mbp_pkg::CFG_CHANNEL_COUNT, 4'd5);
        plan_cfg(mbp_pkg::CFG_WIDTH_LOG2, 4'd15);
        plan_cfg(mbp_pkg::CFG_HEIGHT_LOG2, 4'd15);
        plan_pix(ones, CHK_PREDICT, none);
        plan_pix({16'h1111, 16'h2222, 16'h4444, 16'h8888}, CHK_PREDICT, none);
        plan_pix(zeros, CHK_PREDICT, none);
        plan_pix({16'hEEEE, 16'hDDDD, 16'hBBBB, 16'h7777}, CHK_PREDICT, none);
        // 2x2 image of full-scale pixels
        plan_cfg(mbp_pkg::CFG_CHANNEL_COUNT, 4'd4);
        plan_cfg(mbp_pkg::CFG_WIDTH_LOG2, 4'd1);
        plan_cfg(mbp_pkg::CFG_HEIGHT_LOG2, 4'd1);
        plan_pix(ones, CHK_NONE, none);
        plan_pix(ones, CHK_NONE, none);
        plan_pix(ones, CHK_NONE, none);
        plan_pix(ones, CHK_ONE, ones_res);

        // reset
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (plan[i]) begin
            if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].value);
            else send_pixel(plan[i].pix, plan[i].chk, plan[i].want);
        end

        // random part: mostly whole small images, some cut short
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            wl = pick_log2();
            hl = pick_log2();
            ch = $urandom_range(0, 7);
            write_reg(mbp_pkg::CFG_WIDTH_LOG2, mbp_pkg::CFG_W'(wl));
            write_reg(mbp_pkg::CFG_HEIGHT_LOG2, mbp_pkg::CFG_W'(hl));
            write_reg(mbp_pkg::CFG_CHANNEL_COUNT, mbp_pkg::CFG_W'(ch));
            gaps_on = ($urandom_range(0, 3) != 0);
            npix = 1 << (((wl > mbp_pkg::MAX_DIM_LOG2) ? mbp_pkg::MAX_DIM_LOG2 : wl) +
                         ((hl > mbp_pkg::MAX_DIM_LOG2) ? mbp_pkg::MAX_DIM_LOG2 : hl));
            if (npix <= 64 && $urandom_range(0, 4) != 0)
                n = npix * $urandom_range(1, 64 / npix);
            else
                n = $urandom_range(1, 48);
            repeat (n) send_pixel(random_pixel(), CHK_PREDICT, none);
            rand_items += n;
        end

        // one whole row of a wide image, cascading through every level
        gaps_on = 1'b1;
        write_reg(mbp_pkg::CFG_WIDTH_LOG2, mbp_pkg::CFG_W'(TAIL_LOG2));
        write_reg(mbp_pkg::CFG_HEIGHT_LOG2, 4'd0);
        write_reg(mbp_pkg::CFG_CHANNEL_COUNT, 4'd4);
        repeat (TAIL_PIX) send_pixel(random_pixel(), CHK_PREDICT, none);

        // one whole column with no idling on either side
        write_reg(mbp_pkg::CFG_WIDTH_LOG2, 4'd0);
        write_reg(mbp_pkg::CFG_HEIGHT_LOG2, mbp_pkg::CFG_W'(TAIL_LOG2));
        write_reg(mbp_pkg::CFG_CHANNEL_COUNT, 4'd4);
        quiet_tail = 1'b1;
        repeat (TAIL_PIX) send_pixel(random_pixel(), CHK_PREDICT, none);

        settle();
        if (errors == 0) begin
            $display("[mipmap_box_pyramid] OK");
        end else begin
            $display("[mipmap_box_pyramid] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mbp_pkg.sv
rtl/core/mbp_ram.sv
rtl/core/mbp_sum_unit.sv
rtl/core/mbp_ctrl.sv
rtl/core/mipmap_box_pyramid.sv
sim/mipmap_box_pyramid_tb.sv
